// ----- design/humidity_temp_frame_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame decoder
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define HTFD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HTFD_ASSERT(lbl, prop, msg) \
  `HTFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define HTFD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define HTFD_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- design/htfd_pkg.sv -----
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 step for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [2:0]  FRAME_LAST  = 3'd6;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  // Completed frame handed from the front end to the back end
  typedef struct packed {
    logic [39:0] payload;
    logic        crc_ok;
    logic        busy;
  } frame_t;

  // Decoded result
  typedef struct packed {
    logic               busy;
    logic               crc_ok;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [19:0]        temp_reading;
    logic [19:0]        hum_reading;
  } result_t;

  // CRC-8, MSB first, no final xor
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/htfd_front.sv -----
// ----------------------------------------------------------------------------
// htfd_front
// Byte tracker: frame position, running CRC and payload shift register.
// ----------------------------------------------------------------------------
module htfd_front import htfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  input  logic       q_full_i,
  output logic       ready_o,
  output logic       push_o,
  output frame_t     frame_o
);

  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic        busy_q, busy_d;
  logic [39:0] payload_q, payload_d;
  logic        accept;
  logic        first;
  logic        last;

  assign ready_o = ~q_full_i;
  assign accept  = valid_i & ready_o;
  assign first   = frame_start_i | (pos_q == 3'd0);
  // positions six and above are handled as the CRC byte
  assign last    = ~first & (pos_q >= FRAME_LAST);

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    busy_d    = busy_q;
    payload_d = payload_q;
    if (accept) begin
      if (first) begin
        crc_d     = crc8_update(CRC_INIT, data_byte_i);
        busy_d    = data_byte_i[7];
        payload_d = '0;
        pos_d     = 3'd1;
      end else if (!last) begin
        crc_d     = crc8_update(crc_q, data_byte_i);
        payload_d = {payload_q[31:0], data_byte_i};
        pos_d     = pos_q + 3'd1;
      end else begin
        crc_d = CRC_INIT;
        pos_d = 3'd0;
      end
    end
  end

  assign push_o         = accept & last;
  assign frame_o.payload = payload_q;
  assign frame_o.crc_ok  = (crc_q == data_byte_i);
  assign frame_o.busy    = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      crc_q  <= CRC_INIT;
      busy_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

endmodule

// ----- design/htfd_fifo.sv -----
// ----------------------------------------------------------------------------
// htfd_fifo
// Small frame queue between the byte tracker and the conversion pipeline.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_defines.svh"

module htfd_fifo import htfd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t data_i,
  input  logic   pop_i,
  output frame_t data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  frame_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `HTFD_ASSERT(a_cnt_bound, cnt_q <= CntFull, "fifo count above depth")
  `HTFD_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full fifo")
  `HTFD_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty fifo")

endmodule

// ----- design/htfd_back.sv -----
// ----------------------------------------------------------------------------
// htfd_back
// Conversion pipeline: scale multiplies, then shift/offset into the output
// register.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_defines.svh"

module htfd_back import htfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  frame_t  frame_i,
  output logic    pop_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic        s1_valid_q;
  logic [19:0] s1_hraw_q, s1_traw_q;
  logic [33:0] s1_hprod_q;
  logic [34:0] s1_tprod_q;
  logic        s1_ok_q, s1_busy_q;
  logic        out_valid_q;
  result_t     out_q;

  logic        out_ready, s1_ready;
  logic [19:0] hraw, traw;
  logic [14:0] tc;

  assign out_ready = ~out_valid_q | ready_i;
  assign s1_ready  = ~s1_valid_q | out_ready;
  assign pop_o     = ~q_empty_i & s1_ready;

  // values are zeroed on a CRC mismatch
  assign hraw = frame_i.crc_ok ? frame_i.payload[39:20] : 20'd0;
  assign traw = frame_i.crc_ok ? frame_i.payload[19:0]  : 20'd0;
  assign tc   = s1_ok_q ? (s1_tprod_q[34:20] - TEMP_OFFSET) : 15'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pop_o;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_hraw_q  <= hraw;
      s1_traw_q  <= traw;
      s1_hprod_q <= {14'd0, hraw} * {20'd0, HUM_SCALE};
      s1_tprod_q <= {15'd0, traw} * {20'd0, TEMP_SCALE};
      s1_ok_q    <= frame_i.crc_ok;
      s1_busy_q  <= frame_i.busy;
    end
    if (out_ready && s1_valid_q) begin
      out_q.hum_reading       <= s1_hraw_q;
      out_q.temp_reading      <= s1_traw_q;
      out_q.humidity_centi    <= s1_hprod_q[33:20];
      out_q.temperature_centi <= tc;
      out_q.crc_ok            <= s1_ok_q;
      out_q.busy              <= s1_busy_q;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

  `HTFD_ASSERT(a_bad_crc_zero,
    (out_valid_q && !out_q.crc_ok) |-> (out_q.hum_reading == 20'd0 &&
      out_q.temp_reading == 20'd0 && out_q.temperature_centi == 15'sd0),
    "values not zeroed on CRC mismatch")
  `HTFD_ASSERT(a_hum_range, out_valid_q |-> (out_q.humidity_centi < HUM_SCALE), "humidity out of range")
  `HTFD_ASSERT(a_s1_hold, (s1_valid_q && !s1_ready) |=> s1_valid_q, "stage 1 dropped while stalled")

endmodule

// ----- design/humidity_temp_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: one byte per cycle on s_axis, no stall unless the queue fills.
// A result reaches m_axis after its CRC byte is accepted, via the queue, multiply stage and output register.
// Reset (async, active low) clears frame position, CRC to 0xFF, queue and pipeline valids.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder import htfd_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] hum_reading, [39:20] temp_reading, [53:40] humidity_centi,
  // [68:54] temperature_centi, [69] crc_ok, [70] busy_res, [71] zero
  output logic [71:0] m_axis_tdata
);

  frame_t  push_frame, pop_frame;
  logic    push, pop, q_full, q_empty;
  result_t res;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .data_byte_i   (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .q_full_i      (q_full),
    .ready_o       (s_axis_tready),
    .push_o        (push),
    .frame_o       (push_frame)
  );

  htfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .pop_i   (pop),
    .data_o  (pop_frame),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  htfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .frame_i   (pop_frame),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .result_o  (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule
